>>> src/spike_train_statistics_top_defines.svh
// Assertion helpers shared by the divider and controller RTL files.
`ifndef SPIKE_TRAIN_STATISTICS_TOP_DEFINES_SVH
`define SPIKE_TRAIN_STATISTICS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define STST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stst assertion failed");

// Next-cycle implication, disabled while in reset.
`define STST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stst assertion failed");

`endif

>>> src/stst_pkg.sv
package stst_pkg;

  localparam int TIME_W = 32;
  localparam int DIVD_W = 48;
  localparam int DIVS_W = 33;
  localparam int CFG_W  = 32;
  localparam int RL_W   = 11;
  localparam int MEAN_W = 16;
  localparam int SUM_W  = 48;

  localparam int BIN_DEPTH_DEF  = 1024;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [0:0] REG_ROW_LENGTH = 1'b0;
  localparam logic [0:0] REG_START_TIME = 1'b1;

  localparam logic [1:0] DIV_IDX  = 2'd0;
  localparam logic [1:0] DIV_ROW  = 2'd1;
  localparam logic [1:0] DIV_TERM = 2'd2;
  localparam logic [1:0] DIV_MEAN = 2'd3;

  typedef struct packed {
    logic       load_item;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cap_idx;
    logic       mem_rd;
    logic       cap_row;
    logic       upd_stats;
    logic       cap_mean;
    logic       out_load;
    logic       clr_step;
  } stst_cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_last;
    logic out_busy;
  } stst_sts_t;

endpackage

>>> src/spike_train_statistics_top.sv
// Spike train statistics: each request on the input stream is one event time
// stamp; the block answers with exactly one result carrying the histogram bin
// hit (time mod row_length, with 0 taken as 1 and capped at BIN_DEPTH), that
// bin's new saturating count, the row number since start_time, the saturating
// event total and the running CV2 mean in unsigned Q2.14 with its valid flag.
// Items are handled one at a time and all four divisions (bin, row, CV2 term,
// mean) share one restoring divider that yields one quotient bit a cycle over
// a 48-bit dividend; the next request is taken only once the result has been
// loaded into the output register. A finished result waits in the output
// register while the next request is already taken. After reset, and after
// every row_length write, a clearing pass zeroes all BIN_DEPTH bins of the bin
// store (1024 by default) one bin a cycle, and no request is taken meanwhile.
module spike_train_statistics_top
  import stst_pkg::*;
#(
  parameter int BIN_DEPTH  = BIN_DEPTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int IB         = $clog2(BIN_DEPTH),
  parameter int OUT_W      = ((IB + COUNT_BITS + 2*TIME_W + MEAN_W + 1 + 7) / 8) * 8
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [TIME_W-1:0] in_tdata,   // event_time
  output logic              out_tvalid,
  input  logic              out_tready,
  // bin_index, bin_count, row_number, event_total, cv2_mean, cv2_valid, zero pad
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data
);

  stst_cmd_t cmd;
  stst_sts_t sts;
  logic      row_write;

  // a row_length write drops all statistics and restarts the clearing pass
  assign row_write = cfg_we && (cfg_addr == REG_ROW_LENGTH);

  stst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .row_write (row_write),
    .sts       (sts),
    .cmd       (cmd)
  );

  stst_dp #(
    .BIN_DEPTH  (BIN_DEPTH),
    .COUNT_BITS (COUNT_BITS),
    .IB         (IB),
    .OUT_W      (OUT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .clr_stats  (row_write),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_time    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> src/stst_div.sv
`include "spike_train_statistics_top_defines.svh"

module stst_div
  import stst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [DIVD_W-1:0] quotient,
  output logic [DIVS_W-1:0] remainder,
  output logic              done
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVS_W:0]   trial;
  logic              ge;

  // one quotient bit a cycle, restoring
  always_comb begin
    trial    = {rem_r, quo_r[DIVD_W-1]};
    ge       = (trial >= {1'b0, divisor});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DIVS_W'(trial - {1'b0, divisor}) : trial[DIVS_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

  `STST_ASSERT_IMP(a_no_restart, start, !busy_r)
  `STST_ASSERT_NXT(a_last_done, busy_r && !start && cnt_r == CNT_W'(1), done_r)

endmodule

>>> src/stst_dp.sv
module stst_dp
  import stst_pkg::*;
#(
  parameter int BIN_DEPTH  = BIN_DEPTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int IB         = $clog2(BIN_DEPTH),
  parameter int OUT_W      = ((IB + COUNT_BITS + 2*TIME_W + MEAN_W + 1 + 7) / 8) * 8
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  stst_cmd_t         cmd,
  output stst_sts_t         sts,
  input  logic              clr_stats,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [TIME_W-1:0] in_time,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata
);

  localparam int PAD_W = OUT_W - (IB + COUNT_BITS + 2*TIME_W + MEAN_W + 1);
  localparam logic [SUM_W-1:0]      SUM_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [RL_W-1:0]       rl_r;
  logic [TIME_W-1:0]     start_r, t_r, prev_time_r, prev_int_r, events_r, terms_r;
  logic [SUM_W-1:0]      sum_r;
  logic [IB-1:0]         idx_r, clr_r;
  logic [COUNT_BITS-1:0] rdata_r, cnt_r;
  logic [TIME_W-1:0]     rows_r;
  logic [MEAN_W-1:0]     mean_r;
  logic                  out_valid_r;
  logic [COUNT_BITS-1:0] mem [BIN_DEPTH];

  logic [DIVS_W-1:0]     len, s, div_den;
  logic [TIME_W-1:0]     b, d, rel;
  logic [DIVD_W-1:0]     div_num, quo;
  logic [DIVS_W-1:0]     rem;
  logic                  div_done;
  logic [MEAN_W-1:0]     term;
  logic [SUM_W:0]        sum_add;
  logic [COUNT_BITS-1:0] cnt_inc;

  always_comb begin
    if (rl_r == '0)
      len = DIVS_W'(1);
    else if (DIVS_W'(rl_r) > DIVS_W'(BIN_DEPTH))
      len = DIVS_W'(BIN_DEPTH);
    else
      len = DIVS_W'(rl_r);
    // wraps when the event lies before start_time
    rel = t_r - start_r;
    b = t_r - prev_time_r;
    s = DIVS_W'(prev_int_r) + DIVS_W'(b);
    d = (b >= prev_int_r) ? (b - prev_int_r) : (prev_int_r - b);
    case (cmd.div_sel)
      DIV_IDX: begin
        div_num = DIVD_W'(t_r);
        div_den = len;
      end
      DIV_ROW: begin
        div_num = DIVD_W'(rel);
        div_den = len;
      end
      DIV_TERM: begin
        div_num = DIVD_W'({d, 15'd0});
        div_den = s;
      end
      default: begin
        div_num = sum_r;
        div_den = DIVS_W'(terms_r);
      end
    endcase
  end

  stst_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  assign term    = (s == '0) ? '0 : quo[MEAN_W-1:0];
  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(term);
  assign cnt_inc = (rdata_r == CNT_MAX) ? rdata_r : rdata_r + 1'b1;

  // bin store: clearing pass or read-modify-write of the bin hit
  always_ff @(posedge clk) begin
    if (cmd.clr_step)
      mem[clr_r] <= '0;
    else if (cmd.cap_row)
      mem[idx_r] <= cnt_inc;
    if (cmd.mem_rd)
      rdata_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) t_r <= in_time;
    if (cmd.cap_idx) idx_r <= rem[IB-1:0];
    if (cmd.cap_row) begin
      cnt_r  <= cnt_inc;
      rows_r <= (quo[TIME_W-1:0] == '1) ? quo[TIME_W-1:0] : quo[TIME_W-1:0] + 1'b1;
    end
    if (cmd.cap_mean) mean_r <= (terms_r == '0) ? '0 : quo[MEAN_W-1:0];
    if (cmd.out_load)
      out_tdata <= {PAD_W'(0), (terms_r != '0), mean_r, events_r, rows_r, cnt_r, idx_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rl_r        <= RL_W'(1024);
      start_r     <= '0;
      clr_r       <= '0;
      prev_time_r <= '0;
      prev_int_r  <= '0;
      events_r    <= '0;
      sum_r       <= '0;
      terms_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == REG_ROW_LENGTH) rl_r <= cfg_data[RL_W-1:0];
      if (cfg_we && cfg_addr == REG_START_TIME) start_r <= cfg_data[TIME_W-1:0];
      if (clr_stats) begin
        clr_r       <= '0;
        prev_time_r <= '0;
        prev_int_r  <= '0;
        events_r    <= '0;
        sum_r       <= '0;
        terms_r     <= '0;
      end else begin
        if (cmd.clr_step) clr_r <= clr_r + 1'b1;
        if (cmd.upd_stats) begin
          if (events_r >= TIME_W'(2)) begin
            sum_r <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            if (terms_r != '1) terms_r <= terms_r + 1'b1;
          end
          if (events_r != '0) prev_int_r <= b;
          prev_time_r <= t_r;
          if (events_r != '1) events_r <= events_r + 1'b1;
        end
      end
      if (cmd.out_load)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign sts.div_done = div_done;
  assign sts.clr_last = (clr_r == IB'(BIN_DEPTH - 1));
  assign sts.out_busy = out_valid_r && !out_tready;

endmodule

>>> src/stst_ctrl.sv
`include "spike_train_statistics_top_defines.svh"

module stst_ctrl
  import stst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      row_write,
  input  stst_sts_t sts,
  output stst_cmd_t cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_D_IDX  = 4'd2;
  localparam logic [3:0] S_W_IDX  = 4'd3;
  localparam logic [3:0] S_D_ROW  = 4'd4;
  localparam logic [3:0] S_W_ROW  = 4'd5;
  localparam logic [3:0] S_D_TERM = 4'd6;
  localparam logic [3:0] S_W_TERM = 4'd7;
  localparam logic [3:0] S_D_MEAN = 4'd8;
  localparam logic [3:0] S_W_MEAN = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_D_IDX;
        end
      end
      S_D_IDX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_IDX;
        state_nxt     = S_W_IDX;
      end
      S_W_IDX: if (sts.div_done) begin
        cmd.cap_idx = 1'b1;
        state_nxt   = S_D_ROW;
      end
      S_D_ROW: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ROW;
        cmd.mem_rd    = 1'b1;
        state_nxt     = S_W_ROW;
      end
      S_W_ROW: if (sts.div_done) begin
        cmd.cap_row = 1'b1;
        state_nxt   = S_D_TERM;
      end
      S_D_TERM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_TERM;
        state_nxt     = S_W_TERM;
      end
      S_W_TERM: begin
        cmd.div_sel = DIV_TERM;
        if (sts.div_done) begin
          cmd.upd_stats = 1'b1;
          state_nxt     = S_D_MEAN;
        end
      end
      S_D_MEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
        state_nxt     = S_W_MEAN;
      end
      S_W_MEAN: begin
        cmd.div_sel = DIV_MEAN;
        if (sts.div_done) begin
          cmd.cap_mean = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        cmd.div_sel = DIV_MEAN;
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (row_write) state_nxt = S_CLR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  `STST_ASSERT_NXT(a_row_write_clears, row_write, state_r == S_CLR)
  `STST_ASSERT_NXT(a_accept_starts, in_tvalid && in_tready, state_r == S_D_IDX)

endmodule
